// File: rtl/fra_pkg.sv
// ---------------------------------------------------------------------------
// fra_pkg: shared types and constants of the flash record ring allocator
// Function, command, status and register index codes, plus fixed widths.
// ---------------------------------------------------------------------------
package fra_pkg;

   // fixed field widths of the configuration registers used by the address unit
   localparam int BASE_W  = 32;
   localparam int GROUP_W = 20;
   localparam int SLOT_W  = 16;

   // geometry floors applied to slots_in_use and groups_in_use
   localparam int MIN_SLOTS  = 3;
   localparam int MIN_GROUPS = 2;

   // erased flash reads back as all ones
   localparam logic [31:0] ERASED_WORD  = 32'hffff_ffff;
   localparam logic [19:0] MARKER_BYTES = 20'd4;

   typedef enum logic [1:0] {
      FN_STORE   = 2'd0,
      FN_LOAD    = 2'd1,
      FN_CLEAN   = 2'd2,
      FN_PRELOAD = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_ERASE      = 3'd1,
      CMD_WRITE_MARK = 3'd2,
      CMD_WRITE_DATA = 3'd3,
      CMD_READ_DATA  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_TOO_LONG  = 2'd1,
      STS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_BASE_ADDRESS   = 3'd0,
      CSR_SLOT_BYTES     = 3'd1,
      CSR_GROUP_BYTES    = 3'd2,
      CSR_SLOTS_IN_USE   = 3'd3,
      CSR_GROUPS_IN_USE  = 3'd4,
      CSR_PAYLOAD_OFFSET = 3'd5,
      CSR_PAYLOAD_LIMIT  = 3'd6,
      CSR_MARKER_WORD    = 3'd7
   } csr_type;

endpackage

// File: rtl/fra_ram.sv
// ---------------------------------------------------------------------------
// fra_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module fra_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fra_addr.sv
// ---------------------------------------------------------------------------
// fra_addr: slot address unit
// base + group * group_bytes + slot * slot_bytes, two pipeline stages.
// ---------------------------------------------------------------------------
module fra_addr #(
   parameter int GW = 3,
   parameter int SW = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [GW-1:0]                grp,
   input  logic [SW-1:0]                slot,
   input  logic [fra_pkg::BASE_W-1:0]   base_address,
   input  logic [fra_pkg::GROUP_W-1:0]  group_bytes,
   input  logic [fra_pkg::SLOT_W-1:0]   slot_bytes,
   output logic                         done,
   output logic [fra_pkg::BASE_W-1:0]   addr
);
   import fra_pkg::*;

   localparam int GPW = GW + GROUP_W;
   localparam int SPW = SW + SLOT_W;

   logic           v1_ff, v1_in;
   logic           v2_ff, v2_in;
   logic [GPW-1:0] gprod_ff, gprod_in;
   logic [SPW-1:0] sprod_ff, sprod_in;
   logic [BASE_W-1:0] addr_ff, addr_in;

   // stage 1: the two products; stage 2: the sum
   always_comb begin
      v1_in    = start;
      v2_in    = v1_ff;
      gprod_in = GPW'(grp) * GPW'(group_bytes);
      sprod_in = SPW'(slot) * SPW'(slot_bytes);
      addr_in  = v1_ff ? (base_address + BASE_W'(gprod_ff) + BASE_W'(sprod_ff)) : addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      gprod_ff <= gprod_in;
      sprod_ff <= sprod_in;
      addr_ff  <= addr_in;
   end

   assign done = v2_ff;
   assign addr = addr_ff;

endmodule

// File: rtl/flash_record_ring_allocator.sv
// ---------------------------------------------------------------------------
// flash_record_ring_allocator: wear-levelled record ring allocator
// Tracks one mark bit per flash record slot in a RAM and turns store, load,
// clean and mark-preload items into flash erase/write/read commands.
// ---------------------------------------------------------------------------
//
//  channel | ports                  | moves
//  --------+------------------------+-------------------------------------
//  req     | req_valid / req_ready  | one item: func, length, slot, mark
//  rsp     | rsp_valid / rsp_ready  | the flash commands of an item, last flag
//  csr     | csr_wr_en              | register write, taken every cycle
//
// Flow: a preload is written from idle. A load scans one slot mark per cycle,
// then builds the read address. An erase sweeps the group's marks at one per
// cycle, then issues the group's erase; a store is a scan plus up to one erase
// per group, then a marker write and a payload write.
// Reset: a clearing pass writes every mark entry, with req_ready low.
// Stalls: the sequencer holds while the result register is full; req_ready is
// high in idle even while a result waits.
// ---------------------------------------------------------------------------
module flash_record_ring_allocator #(
   parameter int MAX_GROUPS = 8,
   parameter int MAX_SLOTS  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fra_pkg::func_type    req_func,
   input  logic [11:0]          req_payload_len,
   input  logic [7:0]           req_slot_number,
   input  logic                 req_mark_present,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fra_pkg::cmd_type     rsp_command,
   output logic [31:0]          rsp_flash_address,
   output logic [19:0]          rsp_byte_count,
   output logic [31:0]          rsp_marker_data,
   output fra_pkg::status_type  rsp_status,
   output logic                 rsp_last,
   // configuration
   input  logic                 csr_wr_en,
   input  fra_pkg::csr_type     csr_index,
   input  logic [31:0]          csr_wr_data
);
   import fra_pkg::*;

   localparam int DEPTH = MAX_GROUPS * MAX_SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int FW    = AW + 1;
   localparam int GW    = $clog2(MAX_GROUPS);
   localparam int SW    = $clog2(MAX_SLOTS);
   localparam int GCW   = $clog2(MAX_GROUPS + 1);
   localparam int SCW   = $clog2(MAX_SLOTS + 1);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_DECIDE = 8'b0000_1000,
      S_ERASE  = 8'b0001_0000,
      S_MARK   = 8'b0010_0000,
      S_ADDR   = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      ACT_ERASE   = 3'd0,
      ACT_MARKER  = 3'd1,
      ACT_PAYLOAD = 3'd2,
      ACT_READ    = 3'd3,
      ACT_STATUS  = 3'd4
   } act_type;

   // configuration registers
   logic [31:0] base_ff,        base_in;
   logic [15:0] slot_bytes_ff,  slot_bytes_in;
   logic [19:0] group_bytes_ff, group_bytes_in;
   logic [5:0]  slots_use_ff,   slots_use_in;
   logic [3:0]  groups_use_ff,  groups_use_in;
   logic [7:0]  pay_offset_ff,  pay_offset_in;
   logic [11:0] pay_limit_ff,   pay_limit_in;
   logic [31:0] marker_ff,      marker_in;

   // sequencer
   state_type   state_ff, state_in;
   func_type    fn_ff, fn_in;
   logic [11:0] len_ff, len_in;
   act_type     act_ff, act_in;
   status_type  stat_ff, stat_in;
   logic        erase_all_ff, erase_all_in;
   logic [AW-1:0] clr_ff, clr_in;

   // scan issue and return
   logic          issuing_ff, issuing_in;
   logic [GW-1:0] sg_ff, sg_in;
   logic [SW-1:0] ss_ff, ss_in;
   logic [FW-1:0] sflat_ff, sflat_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          pend_last_ff, pend_last_in;
   logic [GW-1:0] pend_g_ff, pend_g_in;
   logic [SW-1:0] pend_s_ff, pend_s_in;
   logic [FW-1:0] pend_flat_ff, pend_flat_in;
   logic          found_ff, found_in;
   logic [GW-1:0] new_g_ff, new_g_in;
   logic [SW-1:0] new_s_ff, new_s_in;
   logic [FW-1:0] new_flat_ff, new_flat_in;

   // erase sweep and mark target
   logic [GW-1:0] era_g_ff, era_g_in;
   logic [SW-1:0] era_cnt_ff, era_cnt_in;
   logic [FW-1:0] era_flat_ff, era_flat_in;
   logic [GW-1:0] mk_g_ff, mk_g_in;
   logic [SW-1:0] mk_s_ff, mk_s_in;
   logic [FW-1:0] mk_flat_ff, mk_flat_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   cmd_type     rsp_cmd_ff, rsp_cmd_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [19:0] rsp_count_ff, rsp_count_in;
   logic [31:0] rsp_md_ff, rsp_md_in;
   status_type  rsp_stat_ff, rsp_stat_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_load;

   // memory and address unit hookup
   logic          ram_wr_en, ram_rd_en, ram_wr_data, ram_rd_data;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic          addr_start, addr_done;
   logic [GW-1:0] addr_g;
   logic [SW-1:0] addr_s;
   logic [31:0]   addr_q;

   // derived geometry and flags
   logic [SCW-1:0] slots_e;
   logic [GCW-1:0] groups_e;
   logic           erase_val, out_free, scan_end, scan_slot_end, era_grp_last;
   logic [31:0]    free_after;
   logic           nxt_wrap;
   logic [GW-1:0]  nxt_g;

   // geometry clamped into the supported range
   always_comb begin
      if (slots_use_ff < 6'(MIN_SLOTS)) begin
         slots_e = SCW'(MIN_SLOTS);
      end else if (32'(slots_use_ff) > 32'(MAX_SLOTS)) begin
         slots_e = SCW'(MAX_SLOTS);
      end else begin
         slots_e = SCW'(slots_use_ff);
      end
      if (groups_use_ff < 4'(MIN_GROUPS)) begin
         groups_e = GCW'(MIN_GROUPS);
      end else if (32'(groups_use_ff) > 32'(MAX_GROUPS)) begin
         groups_e = GCW'(MAX_GROUPS);
      end else begin
         groups_e = GCW'(groups_use_ff);
      end
   end

   assign erase_val     = (marker_ff == ERASED_WORD);
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign scan_slot_end = (32'(ss_ff) + 32'd1 == 32'(slots_e));
   assign scan_end      = scan_slot_end && (32'(sg_ff) + 32'd1 == 32'(groups_e));
   assign era_grp_last  = (32'(era_g_ff) + 32'd1 == 32'(groups_e));
   assign free_after    = 32'(slots_e) - 32'(new_s_ff) - 32'd1;
   assign nxt_wrap      = (32'(new_g_ff) + 32'd1 >= 32'(groups_e));
   assign nxt_g         = nxt_wrap ? '0 : GW'(32'(new_g_ff) + 32'd1);
   assign req_ready     = (state_ff == S_IDLE);

   // configuration writes
   always_comb begin
      base_in        = base_ff;
      slot_bytes_in  = slot_bytes_ff;
      group_bytes_in = group_bytes_ff;
      slots_use_in   = slots_use_ff;
      groups_use_in  = groups_use_ff;
      pay_offset_in  = pay_offset_ff;
      pay_limit_in   = pay_limit_ff;
      marker_in      = marker_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_ADDRESS:   base_in        = csr_wr_data;
            CSR_SLOT_BYTES:     slot_bytes_in  = csr_wr_data[15:0];
            CSR_GROUP_BYTES:    group_bytes_in = csr_wr_data[19:0];
            CSR_SLOTS_IN_USE:   slots_use_in   = csr_wr_data[5:0];
            CSR_GROUPS_IN_USE:  groups_use_in  = csr_wr_data[3:0];
            CSR_PAYLOAD_OFFSET: pay_offset_in  = csr_wr_data[7:0];
            CSR_PAYLOAD_LIMIT:  pay_limit_in   = csr_wr_data[11:0];
            CSR_MARKER_WORD:    marker_in      = csr_wr_data;
            default: ;
         endcase
      end
   end

   // main sequencer
   always_comb begin
      state_in      = state_ff;
      fn_in         = fn_ff;
      len_in        = len_ff;
      act_in        = act_ff;
      stat_in       = stat_ff;
      erase_all_in  = erase_all_ff;
      clr_in        = clr_ff;
      issuing_in    = issuing_ff;
      sg_in         = sg_ff;
      ss_in         = ss_ff;
      sflat_in      = sflat_ff;
      pend_valid_in = 1'b0;
      pend_last_in  = pend_last_ff;
      pend_g_in     = pend_g_ff;
      pend_s_in     = pend_s_ff;
      pend_flat_in  = pend_flat_ff;
      found_in      = found_ff;
      new_g_in      = new_g_ff;
      new_s_in      = new_s_ff;
      new_flat_in   = new_flat_ff;
      era_g_in      = era_g_ff;
      era_cnt_in    = era_cnt_ff;
      era_flat_in   = era_flat_ff;
      mk_g_in       = mk_g_ff;
      mk_s_in       = mk_s_ff;
      mk_flat_in    = mk_flat_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = clr_ff;
      ram_wr_data   = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = sflat_ff[AW-1:0];
      addr_start    = 1'b0;
      addr_g        = mk_g_ff;
      addr_s        = mk_s_ff;
      rsp_load      = 1'b0;

      case (state_ff)
         // clearing pass after reset
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = 1'b0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               fn_in  = req_func;
               len_in = req_payload_len;
               case (req_func)
                  FN_STORE, FN_LOAD: begin
                     if (req_func == FN_STORE && req_payload_len > pay_limit_ff) begin
                        act_in   = ACT_STATUS;
                        stat_in  = STS_TOO_LONG;
                        state_in = S_OUT;
                     end else begin
                        issuing_in = 1'b1;
                        sg_in      = '0;
                        ss_in      = '0;
                        sflat_in   = '0;
                        found_in   = 1'b0;
                        state_in   = S_SCAN;
                     end
                  end
                  FN_CLEAN: begin
                     erase_all_in = 1'b1;
                     era_g_in     = '0;
                     era_cnt_in   = '0;
                     era_flat_in  = '0;
                     state_in     = S_ERASE;
                  end
                  FN_PRELOAD: begin
                     if (32'(req_slot_number) < 32'(DEPTH)) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(req_slot_number);
                        ram_wr_data = req_mark_present;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // one mark read issued per cycle; the RAM returns the data registered
         S_SCAN: begin
            if (issuing_ff) begin
               ram_rd_en     = 1'b1;
               pend_valid_in = 1'b1;
               pend_g_in     = sg_ff;
               pend_s_in     = ss_ff;
               pend_flat_in  = sflat_ff;
               pend_last_in  = scan_end;
               sflat_in      = sflat_ff + FW'(1);
               if (scan_end) begin
                  issuing_in = 1'b0;
               end else if (scan_slot_end) begin
                  sg_in = sg_ff + GW'(1);
                  ss_in = '0;
               end else begin
                  ss_in = ss_ff + SW'(1);
               end
            end
            if (pend_valid_ff) begin
               if (ram_rd_data) begin
                  found_in    = 1'b1;
                  new_g_in    = pend_g_ff;
                  new_s_in    = pend_s_ff;
                  new_flat_in = pend_flat_ff;
               end
               // newest record ends at the first unmarked slot after a mark
               if ((!ram_rd_data && found_ff) || pend_last_ff) begin
                  pend_valid_in = 1'b0;
                  issuing_in    = 1'b0;
                  state_in      = S_DECIDE;
               end
            end
         end

         S_DECIDE: begin
            if (fn_ff == FN_LOAD) begin
               if (found_ff) begin
                  addr_start = 1'b1;
                  addr_g     = new_g_ff;
                  addr_s     = new_s_ff;
                  act_in     = ACT_READ;
                  state_in   = S_ADDR;
               end else begin
                  act_in   = ACT_STATUS;
                  stat_in  = STS_NOT_FOUND;
                  state_in = S_OUT;
               end
            end else if (!found_ff) begin
               // empty ring: erase everything, then use slot 0
               erase_all_in = 1'b1;
               era_g_in     = '0;
               era_cnt_in   = '0;
               era_flat_in  = '0;
               mk_g_in      = '0;
               mk_s_in      = '0;
               mk_flat_in   = '0;
               state_in     = S_ERASE;
            end else if (free_after == 32'd1) begin
               // one slot left: pre-erase the next group
               erase_all_in = 1'b0;
               era_g_in     = nxt_g;
               era_cnt_in   = '0;
               era_flat_in  = nxt_wrap ? '0 : FW'(new_flat_ff + FW'(2));
               mk_g_in      = new_g_ff;
               mk_s_in      = new_s_ff + SW'(1);
               mk_flat_in   = new_flat_ff + FW'(1);
               state_in     = S_ERASE;
            end else if (free_after >= 32'd2) begin
               mk_g_in    = new_g_ff;
               mk_s_in    = new_s_ff + SW'(1);
               mk_flat_in = new_flat_ff + FW'(1);
               state_in   = S_MARK;
            end else begin
               // group full: jump to the next group's first slot
               mk_g_in    = nxt_g;
               mk_s_in    = '0;
               mk_flat_in = nxt_wrap ? '0 : FW'(new_flat_ff + FW'(1));
               state_in   = S_MARK;
            end
         end

         // rewrite one group's marks, one per cycle
         S_ERASE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = era_flat_ff[AW-1:0];
            ram_wr_data = erase_val;
            era_flat_in = era_flat_ff + FW'(1);
            era_cnt_in  = era_cnt_ff + SW'(1);
            if (32'(era_cnt_ff) + 32'd1 == 32'(slots_e)) begin
               addr_start = 1'b1;
               addr_g     = era_g_ff;
               addr_s     = '0;
               act_in     = ACT_ERASE;
               state_in   = S_ADDR;
            end
         end

         S_MARK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = mk_flat_ff[AW-1:0];
            ram_wr_data = 1'b1;
            addr_start  = 1'b1;
            act_in      = ACT_MARKER;
            state_in    = S_ADDR;
         end

         S_ADDR: begin
            if (addr_done) begin
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               case (act_ff)
                  ACT_ERASE: begin
                     if (erase_all_ff && !era_grp_last) begin
                        era_g_in   = era_g_ff + GW'(1);
                        era_cnt_in = '0;
                        state_in   = S_ERASE;
                     end else if (fn_ff == FN_CLEAN) begin
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_MARK;
                     end
                  end
                  ACT_MARKER: act_in   = ACT_PAYLOAD;
                  default:    state_in = S_IDLE;
               endcase
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // result fields for the current action
   always_comb begin
      rsp_cmd_in   = CMD_NONE;
      rsp_addr_in  = '0;
      rsp_count_in = '0;
      rsp_md_in    = '0;
      rsp_stat_in  = STS_OK;
      rsp_last_in  = 1'b1;
      case (act_ff)
         ACT_ERASE: begin
            rsp_cmd_in   = CMD_ERASE;
            rsp_addr_in  = addr_q;
            rsp_count_in = group_bytes_ff;
            rsp_last_in  = (fn_ff == FN_CLEAN) && erase_all_ff && era_grp_last;
         end
         ACT_MARKER: begin
            rsp_cmd_in   = CMD_WRITE_MARK;
            rsp_addr_in  = addr_q;
            rsp_count_in = MARKER_BYTES;
            rsp_md_in    = marker_ff;
            rsp_last_in  = 1'b0;
         end
         ACT_PAYLOAD: begin
            rsp_cmd_in   = CMD_WRITE_DATA;
            rsp_addr_in  = addr_q + 32'(pay_offset_ff);
            rsp_count_in = 20'(len_ff);
         end
         ACT_READ: begin
            rsp_cmd_in   = CMD_READ_DATA;
            rsp_addr_in  = addr_q + 32'(pay_offset_ff);
            rsp_count_in = 20'(len_ff);
         end
         ACT_STATUS: begin
            rsp_stat_in = stat_ff;
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         issuing_ff     <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         base_ff        <= 32'd0;
         slot_bytes_ff  <= 16'd64;
         group_bytes_ff <= 20'd2048;
         slots_use_ff   <= 6'd32;
         groups_use_ff  <= 4'd8;
         pay_offset_ff  <= 8'd4;
         pay_limit_ff   <= 12'd60;
         marker_ff      <= 32'd0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         issuing_ff     <= issuing_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         base_ff        <= base_in;
         slot_bytes_ff  <= slot_bytes_in;
         group_bytes_ff <= group_bytes_in;
         slots_use_ff   <= slots_use_in;
         groups_use_ff  <= groups_use_in;
         pay_offset_ff  <= pay_offset_in;
         pay_limit_ff   <= pay_limit_in;
         marker_ff      <= marker_in;
      end
   end

   // payload and bookkeeping registers
   always_ff @(posedge clock) begin
      fn_ff        <= fn_in;
      len_ff       <= len_in;
      act_ff       <= act_in;
      stat_ff      <= stat_in;
      erase_all_ff <= erase_all_in;
      sg_ff        <= sg_in;
      ss_ff        <= ss_in;
      sflat_ff     <= sflat_in;
      pend_last_ff <= pend_last_in;
      pend_g_ff    <= pend_g_in;
      pend_s_ff    <= pend_s_in;
      pend_flat_ff <= pend_flat_in;
      found_ff     <= found_in;
      new_g_ff     <= new_g_in;
      new_s_ff     <= new_s_in;
      new_flat_ff  <= new_flat_in;
      era_g_ff     <= era_g_in;
      era_cnt_ff   <= era_cnt_in;
      era_flat_ff  <= era_flat_in;
      mk_g_ff      <= mk_g_in;
      mk_s_ff      <= mk_s_in;
      mk_flat_ff   <= mk_flat_in;
      if (rsp_load) begin
         rsp_cmd_ff   <= rsp_cmd_in;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_count_ff <= rsp_count_in;
         rsp_md_ff    <= rsp_md_in;
         rsp_stat_ff  <= rsp_stat_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = rsp_cmd_ff;
   assign rsp_flash_address = rsp_addr_ff;
   assign rsp_byte_count    = rsp_count_ff;
   assign rsp_marker_data   = rsp_md_ff;
   assign rsp_status        = rsp_stat_ff;
   assign rsp_last          = rsp_last_ff;

   // slot mark store
   fra_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_marks (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // slot address computation
   fra_addr #(
      .GW (GW),
      .SW (SW)
   ) u_addr (
      .clock        (clock),
      .reset        (reset),
      .start        (addr_start),
      .grp          (addr_g),
      .slot         (addr_s),
      .base_address (base_ff),
      .group_bytes  (group_bytes_ff),
      .slot_bytes   (slot_bytes_ff),
      .done         (addr_done),
      .addr         (addr_q)
   );

   // marks are only read during a scan, which never writes them
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("mark RAM read and written in the same cycle");

   // read data returning from the RAM is consumed only by the scan
   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == S_SCAN))
      else $error("scan read returned outside the scan");

   // the address unit answers only while the sequencer waits for it
   a_addr_wait: assert property (@(posedge clock) disable iff (reset)
      addr_done |-> (state_ff == S_ADDR))
      else $error("address result arrived outside the wait state");

   // new marker and erase sweep stay inside the active ring
   a_mark_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> (32'(mk_flat_ff) < 32'(groups_e) * 32'(slots_e)))
      else $error("marker slot outside the ring");

   a_erase_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERASE) |-> (32'(era_flat_ff) < 32'(groups_e) * 32'(slots_e)))
      else $error("erase sweep outside the ring");

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for the flash record ring allocator
// Drives store, load, clean and mark-preload items through a valid/ready
// driver, and predicts the flash commands each one should produce from a
// local copy of the slot marks and ring registers. A clocked monitor
// compares every result in order. Register settings change between phases
// once the block has drained.
// ---------------------------------------------------------------------------
module tb;
   import fra_pkg::*;

   localparam int MAX_GROUPS    = 8;
   localparam int MAX_SLOTS     = 32;
   localparam int MARK_DEPTH    = MAX_GROUPS * MAX_SLOTS;
   localparam int SETTLE_CYCLES = MARK_DEPTH + 16;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      func_type    func;
      logic [11:0] len;
      logic [7:0]  slot;
      logic        mark;
   } ring_req_t;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] addr;
      logic [19:0] count;
      logic [31:0] mdata;
      status_type  status;
      logic        last;
   } flash_cmd_t;

   // clock, reset and block ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   func_type    req_func = FN_STORE;
   logic [11:0] req_payload_len = '0;
   logic [7:0]  req_slot_number = '0;
   logic        req_mark_present = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   cmd_type     rsp_command;
   logic [31:0] rsp_flash_address;
   logic [19:0] rsp_byte_count;
   logic [31:0] rsp_marker_data;
   status_type  rsp_status;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   csr_type     csr_index = CSR_BASE_ADDRESS;
   logic [31:0] csr_wr_data = '0;

   // local copy of the ring registers, reset values
   logic [31:0] base_cfg   = 32'd0;
   logic [15:0] slot_cfg   = 16'd64;
   logic [19:0] group_cfg  = 20'd2048;
   logic [5:0]  slots_cfg  = 6'd32;
   logic [3:0]  groups_cfg = 4'd8;
   logic [7:0]  offset_cfg = 8'd4;
   logic [11:0] limit_cfg  = 12'd60;
   logic [31:0] marker_cfg = 32'd0;
   bit          mark_bits [MARK_DEPTH];

   ring_req_t   pending_reqs[$];
   flash_cmd_t  flash_cmds_due[$];
   ring_req_t   req_now;

   int          req_gap = 0;
   int          rsp_stall = 0;
   int          hold_left = 0;
   int          idle_odds = 6;
   bit          stall_phase = 1'b0;
   bit          long_hold_done = 1'b0;
   int          mismatches = 0;
   int          cycle_count = 0;

   flash_record_ring_allocator #(
      .MAX_GROUPS(MAX_GROUPS),
      .MAX_SLOTS (MAX_SLOTS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_payload_len  (req_payload_len),
      .req_slot_number  (req_slot_number),
      .req_mark_present (req_mark_present),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command      (rsp_command),
      .rsp_flash_address(rsp_flash_address),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_marker_data  (rsp_marker_data),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // geometry is saturated into the supported range wherever it is used
   function automatic int unsigned ring_slots();
      if (slots_cfg < MIN_SLOTS) return MIN_SLOTS;
      if (slots_cfg > MAX_SLOTS) return MAX_SLOTS;
      return slots_cfg;
   endfunction

   function automatic int unsigned ring_groups();
      if (groups_cfg < MIN_GROUPS) return MIN_GROUPS;
      if (groups_cfg > MAX_GROUPS) return MAX_GROUPS;
      return groups_cfg;
   endfunction

   function automatic logic [31:0] slot_address(int unsigned g, int unsigned s);
      return base_cfg + 32'(g) * {12'd0, group_cfg} + 32'(s) * {16'd0, slot_cfg};
   endfunction

   function automatic void queue_cmd(cmd_type c, logic [31:0] a, logic [19:0] n,
                                     logic [31:0] m, status_type st);
      flash_cmd_t fc;
      fc.cmd    = c;
      fc.addr   = a;
      fc.count  = n;
      fc.mdata  = m;
      fc.status = st;
      fc.last   = 1'b0;
      flash_cmds_due.push_back(fc);
   endfunction

   // erased flash reads back as the marker only when the marker is all ones
   function automatic void erase_ring_group(int unsigned g);
      int unsigned slots;
      bit          fill;
      slots = ring_slots();
      fill  = (marker_cfg == ERASED_WORD);
      for (int unsigned s = 0; s < slots; s++)
         mark_bits[g * slots + s] = fill;
      queue_cmd(CMD_ERASE, base_cfg + 32'(g) * {12'd0, group_cfg}, group_cfg, 32'd0, STS_OK);
   endfunction

   // newest record: last marked slot of the first run of marked slots
   function automatic bit newest_record(output int unsigned ng, output int unsigned ns);
      int unsigned slots;
      int unsigned groups;
      bit          found;
      slots  = ring_slots();
      groups = ring_groups();
      found  = 1'b0;
      ng     = 0;
      ns     = 0;
      for (int unsigned g = 0; g < groups; g++) begin
         for (int unsigned s = 0; s < slots; s++) begin
            if (mark_bits[g * slots + s]) begin
               ng    = g;
               ns    = s;
               found = 1'b1;
            end else if (found) begin
               return 1'b1;
            end
         end
      end
      return found;
   endfunction

   function automatic void predict_flash_ops(ring_req_t it);
      int unsigned slots;
      int unsigned groups;
      int unsigned g;
      int unsigned s;
      int unsigned nxt;
      int unsigned free_after;
      int unsigned first;
      logic [31:0] a;
      slots  = ring_slots();
      groups = ring_groups();
      g      = 0;
      s      = 0;
      first  = flash_cmds_due.size();
      case (it.func)
         FN_STORE: begin
            if (it.len > limit_cfg) begin
               queue_cmd(CMD_NONE, 32'd0, 20'd0, 32'd0, STS_TOO_LONG);
            end else begin
               if (!newest_record(g, s)) begin
                  // empty ring: wipe everything and start at the first slot
                  for (int unsigned k = 0; k < groups; k++)
                     erase_ring_group(k);
                  g = 0;
                  s = 0;
               end else begin
                  free_after = slots - s - 1;
                  nxt        = (g + 1 >= groups) ? 0 : g + 1;
                  if (free_after == 1) begin
                     // last free slot: pre-erase the following group
                     erase_ring_group(nxt);
                     s++;
                  end else if (free_after >= 2) begin
                     s++;
                  end else begin
                     g = nxt;
                     s = 0;
                  end
               end
               a = slot_address(g, s);
               mark_bits[g * slots + s] = 1'b1;
               queue_cmd(CMD_WRITE_MARK, a, MARKER_BYTES, marker_cfg, STS_OK);
               queue_cmd(CMD_WRITE_DATA, a + 32'(offset_cfg), 20'(it.len), 32'd0, STS_OK);
            end
         end
         FN_LOAD: begin
            if (newest_record(g, s))
               queue_cmd(CMD_READ_DATA, slot_address(g, s) + 32'(offset_cfg), 20'(it.len),
                         32'd0, STS_OK);
            else
               queue_cmd(CMD_NONE, 32'd0, 20'd0, 32'd0, STS_NOT_FOUND);
         end
         FN_CLEAN: begin
            for (int unsigned k = 0; k < groups; k++)
               erase_ring_group(k);
         end
         default: begin
            mark_bits[it.slot] = it.mark;
         end
      endcase
      if (flash_cmds_due.size() > first)
         flash_cmds_due[flash_cmds_due.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Driver: request channel
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_flash_ops(req_now);
         if (!(req_valid && !req_ready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                  req_gap = $urandom_range(0, 12);
                  req_valid <= 1'b0;
               end else begin
                  req_now = pending_reqs.pop_front();
                  req_valid        <= 1'b1;
                  req_func         <= req_now.func;
                  req_payload_len  <= req_now.len;
                  req_slot_number  <= req_now.slot;
                  req_mark_present <= req_now.mark;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: result channel
   // ------------------------------------------------------------------
   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      flash_cmd_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (flash_cmds_due.size() == 0) begin
               flag_mismatch("unexpected result command", rsp_command, 32'd0);
            end else begin
               want = flash_cmds_due.pop_front();
               if (rsp_command !== want.cmd)
                  flag_mismatch("command", rsp_command, want.cmd);
               if (rsp_flash_address !== want.addr)
                  flag_mismatch("flash_address", rsp_flash_address, want.addr);
               if (rsp_byte_count !== want.count)
                  flag_mismatch("byte_count", rsp_byte_count, want.count);
               if (rsp_marker_data !== want.mdata)
                  flag_mismatch("marker_data", rsp_marker_data, want.mdata);
               if (rsp_status !== want.status)
                  flag_mismatch("status", rsp_status, want.status);
               if (rsp_last !== want.last)
                  flag_mismatch("last", rsp_last, want.last);
            end
         end
         // back-pressure: random stall bursts, plus one long hold-off in the stall phase
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_phase && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_stall = $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic write_reg(csr_type idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_BASE_ADDRESS:   base_cfg   = val;
         CSR_SLOT_BYTES:     slot_cfg   = val[15:0];
         CSR_GROUP_BYTES:    group_cfg  = val[19:0];
         CSR_SLOTS_IN_USE:   slots_cfg  = val[5:0];
         CSR_GROUPS_IN_USE:  groups_cfg = val[3:0];
         CSR_PAYLOAD_OFFSET: offset_cfg = val[7:0];
         CSR_PAYLOAD_LIMIT:  limit_cfg  = val[11:0];
         default:            marker_cfg = val;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic program_ring(logic [31:0] base, logic [15:0] sbytes, logic [19:0] gbytes,
                               logic [5:0] slots, logic [3:0] groups, logic [7:0] offset,
                               logic [11:0] limit, logic [31:0] marker);
      write_reg(CSR_BASE_ADDRESS, base);
      write_reg(CSR_SLOT_BYTES, {16'd0, sbytes});
      write_reg(CSR_GROUP_BYTES, {12'd0, gbytes});
      write_reg(CSR_SLOTS_IN_USE, {26'd0, slots});
      write_reg(CSR_GROUPS_IN_USE, {28'd0, groups});
      write_reg(CSR_PAYLOAD_OFFSET, {24'd0, offset});
      write_reg(CSR_PAYLOAD_LIMIT, {20'd0, limit});
      write_reg(CSR_MARKER_WORD, marker);
   endtask

   // small rings mostly, so stores wrap around often
   task automatic program_random_ring(bit erased_marker);
      logic [31:0] marker;
      marker = (erased_marker || $urandom_range(0, 3) == 0) ? ERASED_WORD : $urandom;
      program_ring($urandom, 16'($urandom_range(0, 16'hffff)), 20'($urandom_range(0, 20'hfffff)),
                   6'($urandom_range(0, 10)), 4'($urandom_range(0, 5)),
                   8'($urandom_range(0, 255)), 12'($urandom_range(0, 200)), marker);
   endtask

   task automatic offer(func_type f, int unsigned len, int unsigned slot, bit mark);
      ring_req_t it;
      it.func = f;
      it.len  = 12'(len);
      it.slot = 8'(slot);
      it.mark = mark;
      pending_reqs.push_back(it);
   endtask

   // mostly store runs with random lengths; loads, cleans and preloads as noise
   task automatic offer_random(int n);
      int unsigned pick;
      int unsigned len;
      int unsigned used;
      used = ring_slots() * ring_groups();
      @(negedge clock);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            if (limit_cfg != 12'hfff && $urandom_range(0, 6) == 0)
               len = $urandom_range(int'(limit_cfg) + 1, 4095);
            else
               len = $urandom_range(0, int'(limit_cfg));
            offer(FN_STORE, len, $urandom_range(0, 255), $urandom_range(0, 1));
         end else if (pick < 70) begin
            offer(FN_LOAD, $urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 1));
         end else if (pick < 75) begin
            offer(FN_CLEAN, $urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 1));
         end else begin
            offer(FN_PRELOAD, $urandom_range(0, 4095),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, used - 1),
                  $urandom_range(0, 1));
         end
      end
   endtask

   // wait for the block to go quiet: nothing queued, offered or expected
   task automatic settle_ring();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || flash_cmds_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: 3 slots x 2 groups, walk every allocation case
      program_ring(32'h0000_1000, 16'h0040, 20'h00100, 6'd3, 4'd2, 8'd4, 12'd60, 32'ha5a5_0001);
      @(negedge clock);
      offer(FN_LOAD, 0, 0, 1'b0);          // empty ring: not found
      offer(FN_STORE, 61, 0, 1'b0);        // one byte over the limit
      offer(FN_STORE, 4095, 255, 1'b1);    // longest length
      offer(FN_STORE, 0, 0, 1'b0);         // empty ring: erase all, slot 0
      offer(FN_STORE, 60, 0, 1'b0);        // exactly the limit
      offer(FN_STORE, 7, 0, 1'b0);         // one slot left: pre-erase next group
      offer(FN_STORE, 8, 0, 1'b0);         // group full: jump to next group
      offer(FN_STORE, 9, 0, 1'b0);
      offer(FN_STORE, 10, 0, 1'b0);        // pre-erase wraps to group 0
      offer(FN_STORE, 11, 0, 1'b0);        // wrap to the first slot
      offer(FN_LOAD, 4095, 0, 1'b0);
      offer(FN_PRELOAD, 4095, 255, 1'b1);  // top of the mark store
      offer(FN_PRELOAD, 0, 1, 1'b1);
      offer(FN_PRELOAD, 0, 2, 1'b1);
      offer(FN_LOAD, 33, 0, 1'b0);
      offer(FN_PRELOAD, 0, 0, 1'b0);
      offer(FN_LOAD, 1, 0, 1'b0);
      offer(FN_CLEAN, 0, 0, 1'b0);         // marks cleared
      offer(FN_LOAD, 5, 0, 1'b0);
      offer(FN_STORE, 60, 0, 1'b0);
      settle_ring();

      // erased flash reads as the marker: clean leaves every slot marked
      program_random_ring(1'b1);
      @(negedge clock);
      offer(FN_CLEAN, 0, 0, 1'b0);
      offer(FN_LOAD, 12, 0, 1'b0);
      offer(FN_STORE, 0, 0, 1'b0);
      offer_random(40);
      settle_ring();

      program_ring(32'h8000_0000, 16'h0020, 20'h00400, 6'd4, 4'd3, 8'd16, 12'd100, 32'h1234_5678);
      offer_random(40);
      settle_ring();

      // long receiver hold-off while the sender keeps offering
      idle_odds = 0;
      stall_phase = 1'b1;
      program_random_ring(1'b0);
      offer_random(40);
      settle_ring();
      idle_odds = 6;

      // largest register values: full geometry, address wrap-around
      program_ring(32'hffff_ffff, 16'hffff, 20'hfffff, 6'h3f, 4'hf, 8'hff, 12'hfff, ERASED_WORD);
      offer_random(12);
      settle_ring();

      // smallest register values
      program_ring(32'h0000_0000, 16'h0000, 20'h00000, 6'd0, 4'd0, 8'd0, 12'd0, 32'd0);
      offer_random(30);
      settle_ring();

      idle_odds = 3;
      program_random_ring(1'b0);
      offer_random(30);
      settle_ring();

      idle_odds = 12;
      program_random_ring(1'b0);
      offer_random(30);
      settle_ring();

      // closing stretch without idling
      idle_odds = 0;
      program_random_ring(1'b0);
      offer_random(40);
      settle_ring();

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
